### hdl/fskm_pkg.sv
// Shared types and constants for the FSK square-wave modulator.
package fskm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIDX_W        = 3;
    localparam int FREQ_W        = 15;
    localparam int BTIME_W       = 20;
    localparam int HALF_W        = 19;
    localparam int PRE_W         = 8;
    localparam int DIV_W         = 20;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;

    localparam logic [DIV_W-1:0] TICKS_PER_SEC = 20'd1000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_FREQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_FREQ  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_BYTE  = 3'd4;

    // divider operations, run in this order for every bit setup
    localparam logic [1:0] DIV_OP_PER0 = 2'd0;
    localparam logic [1:0] DIV_OP_PER1 = 2'd1;
    localparam logic [1:0] DIV_OP_CYC0 = 2'd2;
    localparam logic [1:0] DIV_OP_CYC1 = 2'd3;

    typedef struct packed {
        logic [FREQ_W-1:0]  zero_freq;
        logic [FREQ_W-1:0]  one_freq;
        logic [BTIME_W-1:0] bit_time;
        logic [PRE_W-1:0]   pre_count;
        logic [PRE_W-1:0]   pre_byte;
    } cfg_t;

    typedef struct packed {
        logic       accept;
        logic       div_start;
        logic [1:0] div_op;
        logic       div_store;
        logic       settle_step;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic bit_end;
        logic nb_end;
        logic found;
        logic div_done;
    } status_t;

endpackage

### hdl/fskm_regs.sv
// Configuration register file.
module fskm_regs import fskm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ZERO_FREQ: cfg_next.zero_freq = cfg_data[FREQ_W-1:0];
                REG_ONE_FREQ:  cfg_next.one_freq  = cfg_data[FREQ_W-1:0];
                REG_BIT_TIME:  cfg_next.bit_time  = cfg_data[BTIME_W-1:0];
                REG_PRE_COUNT: cfg_next.pre_count = cfg_data[PRE_W-1:0];
                REG_PRE_BYTE:  cfg_next.pre_byte  = cfg_data[PRE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_freq <= 15'd1200;
            cfg_reg.one_freq  <= 15'd2200;
            cfg_reg.bit_time  <= 20'd833;
            cfg_reg.pre_count <= 8'd4;
            cfg_reg.pre_byte  <= 8'd85;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/fskm_div.sv
// Restoring divider, one quotient bit per cycle.
module fskm_div import fskm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   rem_sub;
    logic             fits;

    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};
    assign quotient  = quo_reg;
    assign done      = done_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

### hdl/fskm_dp.sv
// Datapath: bit serializer, tone timing, tone table and result register.
module fskm_dp import fskm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  cfg_t        cfg,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        new_message,
    input  logic        last_byte,
    output status_t     st,
    output logic        pin_level,
    output logic        busy_res,
    output logic        accepted,
    output logic        message_done
);

    logic [7:0]         shift_byte_reg, shift_byte_next;
    logic [7:0]         held_data_reg, held_data_next;
    logic [BIDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [PRE_W-1:0]   pre_left_reg, pre_left_next;
    logic [HALF_W-1:0]  half_ticks_reg, half_ticks_next;
    logic [HALF_W-1:0]  tick_count_reg, tick_count_next;
    logic [DIV_W-1:0]   cycles_left_reg, cycles_left_next;
    logic               phase_high_reg, phase_high_next;
    logic               active_reg, active_next;
    logic               last_flag_reg, last_flag_next;
    logic               pin_hold_reg, pin_hold_next;
    logic               acc_reg, acc_next;

    // per-bit tone table: period and cycle count for a zero and a one bit
    logic [DIV_W-1:0]   per0_reg, per0_next;
    logic [DIV_W-1:0]   per1_reg, per1_next;
    logic [DIV_W-1:0]   cyc0_reg, cyc0_next;
    logic [DIV_W-1:0]   cyc1_reg, cyc1_next;

    logic               pin_level_reg, pin_level_next;
    logic               busy_res_reg, busy_res_next;
    logic               accepted_reg, accepted_next;
    logic               done_reg, done_next;

    logic [DIV_W-1:0]   div_a;
    logic [DIV_W-1:0]   div_b;
    logic [DIV_W-1:0]   div_q;
    logic               div_done;

    logic               cur_bit;
    logic [DIV_W-1:0]   cur_cyc;
    logic [DIV_W-1:0]   cur_per;
    logic               found;
    logic               nb_end;
    logic [HALF_W-1:0]  tick_inc;
    logic               tick_wrap;
    logic [DIV_W-1:0]   cyc_dec;
    logic               bit_end;
    logic [PRE_W-1:0]   pre_left_dec;
    logic               do_nb;

    assign cur_bit      = shift_byte_reg[bit_index_reg];
    assign cur_cyc      = cur_bit ? cyc1_reg : cyc0_reg;
    assign cur_per      = cur_bit ? per1_reg : per0_reg;
    assign found        = cur_cyc != '0;
    assign nb_end       = (bit_index_reg == '0) && (pre_left_reg == '0);
    assign tick_inc     = tick_count_reg + HALF_W'(1);
    assign tick_wrap    = tick_inc >= half_ticks_reg;
    assign cyc_dec      = cycles_left_reg - DIV_W'(1);
    assign bit_end      = tick_wrap && !phase_high_reg && (cyc_dec == '0);
    assign pre_left_dec = pre_left_reg - PRE_W'(1);

    assign st.active   = active_reg;
    assign st.bit_end  = bit_end;
    assign st.nb_end   = nb_end;
    assign st.found    = found;
    assign st.div_done = div_done;

    assign pin_level    = pin_level_reg;
    assign busy_res     = busy_res_reg;
    assign accepted     = accepted_reg;
    assign message_done = done_reg;

    always_comb
    begin
        case (cmd.div_op)
            DIV_OP_PER0:
            begin
                div_a = TICKS_PER_SEC;
                div_b = {{(DIV_W-FREQ_W){1'b0}}, cfg.zero_freq};
            end
            DIV_OP_PER1:
            begin
                div_a = TICKS_PER_SEC;
                div_b = {{(DIV_W-FREQ_W){1'b0}}, cfg.one_freq};
            end
            DIV_OP_CYC0:
            begin
                div_a = cfg.bit_time;
                div_b = per0_reg;
            end
            DIV_OP_CYC1:
            begin
                div_a = cfg.bit_time;
                div_b = per1_reg;
            end
            default:
            begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    fskm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        shift_byte_next  = shift_byte_reg;
        held_data_next   = held_data_reg;
        bit_index_next   = bit_index_reg;
        pre_left_next    = pre_left_reg;
        half_ticks_next  = half_ticks_reg;
        tick_count_next  = tick_count_reg;
        cycles_left_next = cycles_left_reg;
        phase_high_next  = phase_high_reg;
        active_next      = active_reg;
        last_flag_next   = last_flag_reg;
        pin_hold_next    = pin_hold_reg;
        acc_next         = acc_reg;
        per0_next        = per0_reg;
        per1_next        = per1_reg;
        cyc0_next        = cyc0_reg;
        cyc1_next        = cyc1_reg;
        pin_level_next   = pin_level_reg;
        busy_res_next    = busy_res_reg;
        accepted_next    = accepted_reg;
        done_next        = done_reg;
        do_nb            = 1'b0;

        if (cmd.accept)
        begin
            pin_hold_next = phase_high_reg;
            acc_next      = action && !active_reg;
            if (action)
            begin
                if (!active_reg)
                begin
                    held_data_next = data_byte;
                    last_flag_next = last_byte;
                    bit_index_next = BIDX_W'(BITS_PER_BYTE - 1);
                    active_next    = 1'b1;
                    if (new_message && (cfg.pre_count != '0))
                    begin
                        pre_left_next   = cfg.pre_count;
                        shift_byte_next = cfg.pre_byte;
                    end
                    else
                    begin
                        pre_left_next   = '0;
                        shift_byte_next = data_byte;
                    end
                end
            end
            else if (active_reg)
            begin
                tick_count_next = tick_inc;
                if (tick_wrap)
                begin
                    tick_count_next = '0;
                    if (phase_high_reg)
                    begin
                        phase_high_next = 1'b0;
                    end
                    else
                    begin
                        // end of a full period
                        phase_high_next  = 1'b1;
                        cycles_left_next = cyc_dec;
                        if (cyc_dec == '0)
                        begin
                            do_nb = 1'b1;
                        end
                    end
                end
            end
        end

        if (cmd.div_store)
        begin
            case (cmd.div_op)
                DIV_OP_PER0: per0_next = (cfg.zero_freq == '0) ? '0 : div_q;
                DIV_OP_PER1: per1_next = (cfg.one_freq == '0) ? '0 : div_q;
                DIV_OP_CYC0: cyc0_next = (per0_reg == '0) ? '0 : div_q;
                DIV_OP_CYC1: cyc1_next = (per1_reg == '0) ? '0 : div_q;
                default:     per0_next = per0_reg;
            endcase
        end

        if (cmd.settle_step)
        begin
            if (found)
            begin
                half_ticks_next  = cur_per[DIV_W-1:1];
                cycles_left_next = cur_cyc;
                tick_count_next  = '0;
                phase_high_next  = 1'b1;
            end
            else
            begin
                // bit without cycles takes no time
                do_nb = 1'b1;
            end
        end

        if (do_nb)
        begin
            if (bit_index_reg != '0)
            begin
                bit_index_next = bit_index_reg - BIDX_W'(1);
            end
            else
            begin
                bit_index_next = BIDX_W'(BITS_PER_BYTE - 1);
                if (pre_left_reg != '0)
                begin
                    pre_left_next   = pre_left_dec;
                    shift_byte_next = (pre_left_dec != '0) ? cfg.pre_byte : held_data_reg;
                end
                else
                begin
                    active_next     = 1'b0;
                    phase_high_next = 1'b0;
                end
            end
        end

        if (cmd.load_out)
        begin
            if (cmd.accept)
            begin
                pin_level_next = phase_high_reg;
            end
            else
            begin
                pin_level_next = acc_reg ? phase_high_next : pin_hold_reg;
            end
            busy_res_next = active_next;
            accepted_next = cmd.accept ? 1'b0 : acc_reg;
            done_next     = do_nb && nb_end && last_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg  <= '0;
            held_data_reg   <= '0;
            bit_index_reg   <= BIDX_W'(BITS_PER_BYTE - 1);
            pre_left_reg    <= '0;
            half_ticks_reg  <= '0;
            tick_count_reg  <= '0;
            cycles_left_reg <= '0;
            phase_high_reg  <= 1'b0;
            active_reg      <= 1'b0;
            last_flag_reg   <= 1'b0;
            pin_hold_reg    <= 1'b0;
            acc_reg         <= 1'b0;
            per0_reg        <= '0;
            per1_reg        <= '0;
            cyc0_reg        <= '0;
            cyc1_reg        <= '0;
            pin_level_reg   <= 1'b0;
            busy_res_reg    <= 1'b0;
            accepted_reg    <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            shift_byte_reg  <= shift_byte_next;
            held_data_reg   <= held_data_next;
            bit_index_reg   <= bit_index_next;
            pre_left_reg    <= pre_left_next;
            half_ticks_reg  <= half_ticks_next;
            tick_count_reg  <= tick_count_next;
            cycles_left_reg <= cycles_left_next;
            phase_high_reg  <= phase_high_next;
            active_reg      <= active_next;
            last_flag_reg   <= last_flag_next;
            pin_hold_reg    <= pin_hold_next;
            acc_reg         <= acc_next;
            per0_reg        <= per0_next;
            per1_reg        <= per1_next;
            cyc0_reg        <= cyc0_next;
            cyc1_reg        <= cyc1_next;
            pin_level_reg   <= pin_level_next;
            busy_res_reg    <= busy_res_next;
            accepted_reg    <= accepted_next;
            done_reg        <= done_next;
        end
    end

endmodule

### hdl/fskm_ctrl.sv
// Controller: word handshakes, divider sequencing and bit setup loop.
module fskm_ctrl import fskm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    action,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DIV_GO   = 2'd1;
    localparam logic [1:0] S_DIV_WAIT = 2'd2;
    localparam logic [1:0] S_SETTLE   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] div_op_reg, div_op_next;
    logic       out_valid_reg, out_valid_next;

    // one item in flight; the result slot is free or being emptied on accept
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.div_op  = div_op_reg;
        state_next  = state_reg;
        div_op_next = div_op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.accept = 1'b1;
                    if (action && !st.active)
                    begin
                        div_op_next = DIV_OP_PER0;
                        state_next  = S_DIV_GO;
                    end
                    else if (!action && st.active && st.bit_end && !st.nb_end)
                    begin
                        div_op_next = DIV_OP_PER0;
                        state_next  = S_DIV_GO;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                    end
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (div_op_reg == DIV_OP_CYC1)
                    begin
                        state_next = S_SETTLE;
                    end
                    else
                    begin
                        div_op_next = div_op_reg + 2'd1;
                        state_next  = S_DIV_GO;
                    end
                end
            end
            S_SETTLE:
            begin
                cmd.settle_step = 1'b1;
                if (st.found || st.nb_end)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_op_reg    <= DIV_OP_PER0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_op_reg    <= div_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten before it was taken");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        st.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside of its wait state");

    a_busy_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> st.active)
        else $error("bit setup running while the modulator is idle");
`endif

endmodule

### hdl/fsk_square_wave_modulator_unit.sv
// Top level of the binary FSK square-wave modulator.
// Each input word is either a one-microsecond tick (action 0) or a byte offer
// (action 1) and yields exactly one result word. A tick inside a bit and any
// rejected or idle word are answered directly. An accepted byte, and a tick that
// ends any bit but the last data bit, set up the next bit: four serial
// divisions on one 20-step divider (tone periods and cycle counts for both bit
// values), then a settle step per bit examined, since bits without tone cycles
// are skipped one per cycle through the rest of the preamble and data byte. One
// word is processed at a time; the result register lets the next word in as
// soon as the previous result is taken or is being taken.
module fsk_square_wave_modulator_unit import fskm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [7:0]            data_byte,
    input  logic                  new_message,
    input  logic                  last_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pin_level,
    output logic                  busy_res,
    output logic                  accepted,
    output logic                  message_done,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;

    fskm_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fskm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    fskm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .action       (action),
        .data_byte    (data_byte),
        .new_message  (new_message),
        .last_byte    (last_byte),
        .st           (st),
        .pin_level    (pin_level),
        .busy_res     (busy_res),
        .accepted     (accepted),
        .message_done (message_done)
    );

endmodule

### bench/fsk_square_wave_modulator_unit_tb.sv
// Self-checking testbench for the FSK square-wave modulator: predicted result words vs. DUT.
`timescale 1ns / 100ps

module fsk_square_wave_modulator_unit_tb;
    import fskm_pkg::*;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int STALL_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;

    typedef enum int {ONES_ANY, ONES_SPARSE, ONES_DENSE} ones_bias_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        logic       new_msg;
        logic       last;
    } word_t;

    typedef struct packed {
        logic pin;
        logic busy;
        logic acc;
        logic done;
    } res_t;

    class fsk_scoreboard;
        logic [FREQ_W-1:0]  zero_hz;
        logic [FREQ_W-1:0]  one_hz;
        logic [BTIME_W-1:0] bit_us;
        logic [PRE_W-1:0]   pre_total;
        logic [PRE_W-1:0]   pre_value;
        logic [7:0]         shift_q;
        logic [7:0]         held_q;
        logic [BIDX_W-1:0]  bit_pos;
        logic [PRE_W-1:0]   pre_left;
        logic [HALF_W-1:0]  half_len;
        logic [HALF_W-1:0]  tick_cnt;
        logic [19:0]        cyc_left;
        logic               phase_hi;
        logic               playing;
        logic               last_q;
        res_t               expected_q[$];
        int                 errors;

        function new();
            zero_hz   = 15'd1200;
            one_hz    = 15'd2200;
            bit_us    = 20'd833;
            pre_total = 8'd4;
            pre_value = 8'd85;
            shift_q   = '0;
            held_q    = '0;
            bit_pos   = BIDX_W'(BITS_PER_BYTE - 1);
            pre_left  = '0;
            half_len  = '0;
            tick_cnt  = '0;
            cyc_left  = '0;
            phase_hi  = 1'b0;
            playing   = 1'b0;
            last_q    = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ZERO_FREQ: zero_hz   = val[FREQ_W-1:0];
                REG_ONE_FREQ:  one_hz    = val[FREQ_W-1:0];
                REG_BIT_TIME:  bit_us    = val[BTIME_W-1:0];
                REG_PRE_COUNT: pre_total = val[PRE_W-1:0];
                REG_PRE_BYTE:  pre_value = val[PRE_W-1:0];
                default: ;
            endcase
        endfunction

        // step past the current bit; 1 when the whole stream has ended
        function bit next_bit();
            if (bit_pos != 0) begin
                bit_pos--;
                return 1'b0;
            end
            bit_pos = BIDX_W'(BITS_PER_BYTE - 1);
            if (pre_left != 0) begin
                pre_left--;
                shift_q = (pre_left != 0) ? pre_value : held_q;
                return 1'b0;
            end
            playing  = 1'b0;
            phase_hi = 1'b0;
            return 1'b1;
        endfunction

        // set up the tone of the current bit, skipping bits without cycles
        function bit load_tone();
            int unsigned hz;
            int unsigned per;
            int unsigned cyc;
            while (playing) begin
                hz  = shift_q[bit_pos] ? one_hz : zero_hz;
                per = (hz != 0) ? 1000000 / hz : 0;
                cyc = (per != 0) ? bit_us / per : 0;
                if (cyc != 0) begin
                    half_len = HALF_W'(per / 2);
                    cyc_left = 20'(cyc);
                    tick_cnt = '0;
                    phase_hi = 1'b1;
                    return 1'b0;
                end
                if (next_bit())
                    return last_q;
            end
            return 1'b0;
        endfunction

        function void note_word(word_t w);
            res_t r;
            r = '0;
            if (w.action == ACT_BYTE) begin
                if (!playing) begin
                    r.acc   = 1'b1;
                    held_q  = w.data;
                    last_q  = w.last;
                    bit_pos = BIDX_W'(BITS_PER_BYTE - 1);
                    playing = 1'b1;
                    if (w.new_msg && pre_total != 0) begin
                        pre_left = pre_total;
                        shift_q  = pre_value;
                    end
                    else begin
                        pre_left = '0;
                        shift_q  = w.data;
                    end
                    r.done = load_tone();
                end
                r.pin = playing ? phase_hi : 1'b0;
            end
            else if (playing) begin
                r.pin = phase_hi;
                tick_cnt++;
                if (tick_cnt >= half_len) begin
                    tick_cnt = '0;
                    if (phase_hi) begin
                        phase_hi = 1'b0;
                    end
                    else begin
                        phase_hi = 1'b1;
                        cyc_left--;
                        if (cyc_left == 0)
                            r.done = next_bit() ? last_q : load_tone();
                    end
                end
            end
            r.busy = playing;
            expected_q.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.pin !== exp_r.pin) begin
                $error("pin_level: expected %0d, actual %0d", exp_r.pin, got.pin);
                errors++;
            end
            if (got.busy !== exp_r.busy) begin
                $error("busy_res: expected %0d, actual %0d", exp_r.busy, got.busy);
                errors++;
            end
            if (got.acc !== exp_r.acc) begin
                $error("accepted: expected %0d, actual %0d", exp_r.acc, got.acc);
                errors++;
            end
            if (got.done !== exp_r.done) begin
                $error("message_done: expected %0d, actual %0d", exp_r.done, got.done);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  action;
    logic [7:0]            data_byte;
    logic                  new_message;
    logic                  last_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  pin_level;
    logic                  busy_res;
    logic                  accepted;
    logic                  message_done;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    fsk_scoreboard sb = new();
    word_t         plan_q[$];
    ones_bias_t    ones_bias = ONES_ANY;
    bit            msg_open = 1'b0;
    bit            hold_req = 1'b0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    fsk_square_wave_modulator_unit DUT (.*);

    always #10 clk = ~clk;

    function automatic logic [7:0] pick_data();
        logic [7:0] v;
        v = 8'($urandom);
        if ($urandom_range(99) < 80) begin
            case (ones_bias)
                ONES_SPARSE: v = v & 8'($urandom) & 8'($urandom);
                ONES_DENSE:  v = v | 8'($urandom) | 8'($urandom);
                default: ;
            endcase
        end
        return v;
    endfunction

    // mostly well-formed messages offered while idle, ticks while playing
    function automatic word_t pick_word();
        word_t w;
        if (plan_q.size() != 0)
            return plan_q.pop_front();
        w.data    = pick_data();
        w.new_msg = 1'($urandom_range(1));
        w.last    = 1'($urandom_range(1));
        if (sb.playing) begin
            w.action = ($urandom_range(99) < 4) ? ACT_BYTE : ACT_TICK;
        end
        else if ($urandom_range(99) < 50) begin
            w.action  = ACT_BYTE;
            w.new_msg = msg_open ? ($urandom_range(9) == 0) : ($urandom_range(9) != 0);
            w.last    = ($urandom_range(99) < 35);
            msg_open  = !w.last;
        end
        else begin
            w.action = ACT_TICK;
        end
        return w;
    endfunction

    task automatic send_words(int n);
        int    sent;
        word_t cur;
        sent = 0;
        cur  = '0;
        while (sent < n) begin
            if (!in_valid || in_ready) begin
                if ($urandom_range(99) < send_idle_pct) begin
                    in_valid <= 1'b0;
                end
                else begin
                    cur = pick_word();
                    action      <= cur.action;
                    data_byte   <= cur.data;
                    new_message <= cur.new_msg;
                    last_byte   <= cur.last;
                    in_valid    <= 1'b1;
                end
            end
            @(posedge clk);
            if (in_valid && in_ready) begin
                sb.note_word(cur);
                sent++;
            end
        end
        in_valid <= 1'b0;
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_config(logic [CFG_DATA_W-1:0] zero_hz, logic [CFG_DATA_W-1:0] one_hz,
                               logic [CFG_DATA_W-1:0] bit_us, logic [CFG_DATA_W-1:0] pre_n,
                               logic [CFG_DATA_W-1:0] pre_b);
        set_reg(REG_ZERO_FREQ, zero_hz);
        set_reg(REG_ONE_FREQ, one_hz);
        set_reg(REG_BIT_TIME, bit_us);
        set_reg(REG_PRE_COUNT, pre_n);
        set_reg(REG_PRE_BYTE, pre_b);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic plan_word(logic act, logic [7:0] d, logic nm, logic lb);
        word_t w;
        w.action  = act;
        w.data    = d;
        w.new_msg = nm;
        w.last    = lb;
        plan_q.push_back(w);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result({pin_level, busy_res, accepted, message_done});
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        clk   = 1'b0;
        rst_n = 1'b0;
        in_valid    <= 1'b0;
        action      <= ACT_TICK;
        data_byte   <= '0;
        new_message <= 1'b0;
        last_byte   <= 1'b0;
        out_ready   <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_ZERO_FREQ;
        cfg_data    <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 47;

        // idle ticks under reset values
        plan_word(ACT_TICK, 8'h00, 1'b0, 1'b0);
        plan_word(ACT_TICK, 8'hFF, 1'b1, 1'b1);
        send_words(2);
        drain();

        // one bits have no cycles, zero bits play one 30-tick cycle
        load_config(20'd32767, 20'd0, 20'd30, 20'd1, 20'h000FF);
        plan_word(ACT_TICK, 8'h00, 1'b0, 1'b0);
        plan_word(ACT_BYTE, 8'hFF, 1'b1, 1'b1);   // all bits skipped, done at once
        plan_word(ACT_BYTE, 8'hFE, 1'b0, 1'b1);   // only the lsb plays
        plan_word(ACT_BYTE, 8'h5A, 1'b1, 1'b0);   // refused while busy
        repeat (20)
            plan_word(ACT_TICK, 8'h00, 1'b0, 1'b0);
        send_words(24);
        drain();

        // 15-bit masking on frequency, 8-bit masking on preamble value
        load_config(20'd1, 20'hF7FFF, 20'd65, 20'd2, 20'hFFF00);
        ones_bias = ONES_SPARSE;
        hold_req  = 1'b1;
        send_words(300);
        drain();

        send_idle_pct = 47;
        recv_idle_pct = 26;
        load_config(20'd20000, 20'd0, 20'd50, 20'd0, 20'h000FF);
        ones_bias = ONES_DENSE;
        send_words(300);
        drain();

        // every bit skipped, longest preamble
        load_config(20'd0, 20'd0, 20'hFFFFF, 20'd255, 20'h000A5);
        ones_bias = ONES_ANY;
        send_words(150);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(20'd16667, 20'd7, 20'd118, 20'd1, 20'h000FE);
        ones_bias = ONES_DENSE;
        send_words(300);
        drain();

        load_config(20'd1200, 20'd2200, 20'd0, 20'd3, 20'h0003C);
        set_reg(REG_UNMAPPED, 20'hFFFFF);
        cfg_valid <= 1'b0;
        ones_bias = ONES_ANY;
        send_words(300);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### fsk_square_wave_modulator_unit.f
hdl/fskm_pkg.sv
hdl/fskm_regs.sv
hdl/fskm_div.sv
hdl/fskm_dp.sv
hdl/fskm_ctrl.sv
hdl/fsk_square_wave_modulator_unit.sv
bench/fsk_square_wave_modulator_unit_tb.sv
